// ===== rtl/tth_pkg.sv =====
package tth_pkg;

  typedef enum logic [2:0] {
    KIND_JET   = 3'd0,
    KIND_EG    = 3'd1,
    KIND_TAU   = 3'd2,
    KIND_SUM   = 3'd3,
    KIND_CLOSE = 3'd4,
    KIND_READ  = 3'd5,
    KIND_RSV6  = 3'd6,
    KIND_RSV7  = 3'd7
  } kind_t;

  localparam logic [1:0] CFG_JET_BINS    = 2'd0;
  localparam logic [1:0] CFG_NARROW_BINS = 2'd1;
  localparam logic [1:0] CFG_WIDE_BINS   = 2'd2;
  localparam logic [1:0] CFG_SHIFT       = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned NCHAN      = 11;
  localparam int unsigned CH_W       = 4;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned MAX_BINS   = 512;
  localparam int unsigned ET_BITS    = 11;

  // Bin-count register selection per channel: 0 jet, 1 narrow, 2 wide.
  localparam logic [1:0] NSEL_JET    = 2'd0;
  localparam logic [1:0] NSEL_NARROW = 2'd1;
  localparam logic [1:0] NSEL_WIDE   = 2'd2;

  function automatic logic [1:0] chan_nsel(input logic [CH_W-1:0] ch);
    logic [1:0] r;
    r = NSEL_NARROW;
    if (ch < 4'd4) r = NSEL_JET;
    else if (ch == 4'd7 || ch == 4'd9) r = NSEL_WIDE;
    return r;
  endfunction

endpackage

// ===== rtl/trigger_threshold_rate_histogrammer_top.sv =====
// Channel | Direction | Ports                                   | Accept when
// in      | input     | in_valid/in_stall, in_kind..in_read_bin | in_valid & !in_stall
// out     | output    | out_valid/out_stall, out_bin_count,     | out_valid & !out_stall
//         |           | out_events_seen                         |
// cfg     | input     | cfg_wr_en, cfg_index, cfg_data          | cfg_wr_en
//
// Object beats (jet, EG, tau, sum) without end_event leave the block idle.
// A read beat passes through memory read, register and output steps.
// Closing an event walks the eleven channels one bin per cycle over the
// read-modify-write pipe of the two count memories, up to each threshold top.
// After reset a clearing pass over all NCHAN*MAX_BINS addresses zeroes both
// memories; in_stall is high during it. out_stall holds the output register
// and, while out_valid is high, also raises in_stall.
module trigger_threshold_rate_histogrammer_top
  import tth_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_kind,
  input  logic [3:0]            in_slot,
  input  logic [10:0]           in_et_value,
  input  logic                  in_end_event,
  input  logic [3:0]            in_read_channel,
  input  logic                  in_read_table,
  input  logic [8:0]            in_read_bin,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_bin_count,
  output logic [31:0]           out_events_seen,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned BIN_W = $clog2(MAX_BINS);
  localparam int unsigned DEPTH = NCHAN * MAX_BINS;
  localparam int unsigned ADR_W = $clog2(DEPTH);
  localparam int unsigned EW    = (ET_BITS < 11) ? ET_BITS : 11;
  localparam logic [BIN_W:0] NB_MAX = (BIN_W+1)'(MAX_BINS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_RD_OUT, ST_CH, ST_WALK, ST_DRAIN
  } state_t;

  // memories
  logic [CNT_W-1:0] rate_mem [DEPTH];
  logic [CNT_W-1:0] dist_mem [DEPTH];

  // configuration
  logic [8:0] jet_bins_r, narrow_bins_r, wide_bins_r;
  logic [2:0] shift_r;

  // per-event values
  logic [10:0] jet_r [4];
  logic [10:0] sum_r [4];
  logic [10:0] eg1_r, eg2_r, tau_r;
  logic [CNT_W-1:0] events_r;

  state_t state_r;
  logic [ADR_W-1:0] clr_adr_r;
  logic [CH_W-1:0]  ch_r;
  logic [BIN_W-1:0] bin_r;
  logic [BIN_W-1:0] top_r;
  logic [BIN_W:0]   dbin_r;
  logic             dfirst_r;

  // read-modify-write pipe: stage 1 holds address issued last cycle
  logic             p1_v_r, p1_dist_r;
  logic [ADR_W-1:0] p1_adr_r;
  logic [CNT_W-1:0] rate_q_r, dist_q_r;

  logic             rd_table_r;
  logic             rd_ok_r;
  logic [ADR_W-1:0] rd_adr;

  // channel value and bin count
  logic [10:0]    ch_val;
  logic [8:0]     nreg;
  logic [BIN_W:0] n_use;
  logic [2:0]     sh_use;
  logic [10:0]    bval;
  logic [BIN_W:0] bsat;

  always_comb begin
    unique case (ch_r)
      4'd0: ch_val = jet_r[0];
      4'd1: ch_val = jet_r[1];
      4'd2: ch_val = jet_r[2];
      4'd3: ch_val = jet_r[3];
      4'd4: ch_val = eg1_r;
      4'd5: ch_val = eg2_r;
      4'd6: ch_val = tau_r;
      4'd7: ch_val = sum_r[1];
      4'd8: ch_val = sum_r[3];
      4'd9: ch_val = sum_r[0];
      4'd10: ch_val = sum_r[2];
      default: ch_val = '0;
    endcase
    unique case (chan_nsel(ch_r))
      NSEL_JET:  nreg = jet_bins_r;
      NSEL_WIDE: nreg = wide_bins_r;
      default:   nreg = narrow_bins_r;
    endcase
    if (nreg == 9'd0) n_use = (BIN_W+1)'(1);
    else if ({2'b0, nreg} > 11'(NB_MAX)) n_use = NB_MAX;
    else n_use = (BIN_W+1)'(nreg);
    sh_use = (shift_r > 3'd6) ? 3'd6 : shift_r;
    bval = ch_val >> sh_use;
    // clip to n_use (the overflow bin index)
    if ({5'b0, bval} >= 16'(n_use)) bsat = n_use;
    else bsat = (BIN_W+1)'(bval);
  end

  logic [ADR_W-1:0] ch_base;
  assign ch_base = ADR_W'(ch_r) * ADR_W'(MAX_BINS);

  logic in_acc;
  assign in_stall = (state_r != ST_IDLE) || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;

  logic [10:0] et_m;
  assign et_m = in_et_value & 11'((1 << EW) - 1);

  logic rd_in_range;
  assign rd_in_range = (in_read_channel < 4'(NCHAN)) && ({1'b0, in_read_bin} < 10'(MAX_BINS));
  assign rd_adr = ADR_W'(in_read_channel) * ADR_W'(MAX_BINS) + ADR_W'(in_read_bin);

  // issue of walk accesses
  logic             iss_v, iss_dist;
  logic [ADR_W-1:0] iss_adr;
  always_comb begin
    iss_v    = (state_r == ST_WALK);
    iss_dist = dfirst_r;
    iss_adr  = dfirst_r ? ch_base + ADR_W'(dbin_r) : ch_base + ADR_W'(bin_r);
  end

  logic [CNT_W-1:0] inc_val;
  assign inc_val = p1_dist_r ?
      ((&dist_q_r) ? dist_q_r : dist_q_r + 1'b1) :
      ((&rate_q_r) ? rate_q_r : rate_q_r + 1'b1);

  // memories: read address from an accepted input beat or the issue, write from the
  // clear counter or stage 1; read data holds when neither reads
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      rate_mem[clr_adr_r] <= '0;
      dist_mem[clr_adr_r] <= '0;
    end else if (p1_v_r) begin
      if (p1_dist_r) dist_mem[p1_adr_r] <= inc_val;
      else rate_mem[p1_adr_r] <= inc_val;
    end
    if (in_acc) begin
      rate_q_r <= rate_mem[rd_adr];
      dist_q_r <= dist_mem[rd_adr];
    end else if (iss_v) begin
      rate_q_r <= rate_mem[iss_adr];
      dist_q_r <= dist_mem[iss_adr];
    end
  end

  // Each address is touched at most once per pass (distinct bins), so the
  // one-deep pipe needs no forwarding.

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_adr_r <= '0;
      jet_bins_r <= 9'd200;
      narrow_bins_r <= 9'd150;
      wide_bins_r <= 9'd300;
      shift_r <= 3'd2;
      for (int i = 0; i < 4; i++) begin
        jet_r[i] <= '0;
        sum_r[i] <= '0;
      end
      eg1_r <= '0;
      eg2_r <= '0;
      tau_r <= '0;
      events_r <= '0;
      out_valid <= 1'b0;
      p1_v_r <= 1'b0;
      ch_r <= '0;
      dfirst_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_JET_BINS:    jet_bins_r <= cfg_data;
          CFG_NARROW_BINS: narrow_bins_r <= cfg_data;
          CFG_WIDE_BINS:   wide_bins_r <= cfg_data;
          CFG_SHIFT:       shift_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      p1_v_r    <= iss_v;
      p1_dist_r <= iss_dist;
      p1_adr_r  <= iss_adr;

      unique case (state_r)
        ST_CLEAR: begin
          clr_adr_r <= clr_adr_r + 1'b1;
          if (clr_adr_r == ADR_W'(DEPTH - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc) begin
            unique case (kind_t'(in_kind))
              KIND_JET: begin
                if (in_slot < 4'd4) jet_r[in_slot[1:0]] <= et_m;
                if (in_end_event) state_r <= ST_CH;
              end
              KIND_EG: begin
                if (et_m >= eg1_r) begin
                  eg2_r <= eg1_r;
                  eg1_r <= et_m;
                end else if (et_m > eg2_r) begin
                  eg2_r <= et_m;
                end
                if (in_end_event) state_r <= ST_CH;
              end
              KIND_TAU: begin
                if (et_m > tau_r) tau_r <= et_m;
                if (in_end_event) state_r <= ST_CH;
              end
              KIND_SUM: begin
                if (in_slot < 4'd4) sum_r[in_slot[1:0]] <= et_m;
                if (in_end_event) state_r <= ST_CH;
              end
              KIND_CLOSE: state_r <= ST_CH;
              KIND_READ: begin
                rd_table_r <= in_read_table;
                rd_ok_r    <= rd_in_range;
                state_r    <= ST_RD;
              end
              default: ;
            endcase
            ch_r <= '0;
          end
        end
        ST_RD: state_r <= ST_RD_OUT;
        ST_RD_OUT: begin
          out_valid       <= 1'b1;
          out_bin_count   <= !rd_ok_r ? '0 : (rd_table_r ? dist_q_r : rate_q_r);
          out_events_seen <= events_r;
          state_r         <= ST_IDLE;
        end
        ST_CH: begin
          dbin_r   <= bsat;
          bin_r    <= '0;
          top_r    <= (bsat == n_use) ? BIN_W'(n_use - 1'b1) : BIN_W'(bsat);
          dfirst_r <= 1'b1;
          state_r  <= ST_WALK;
        end
        ST_WALK: begin
          if (dfirst_r) dfirst_r <= 1'b0;
          else if (bin_r == top_r) begin
            if (ch_r == CH_W'(NCHAN - 1)) state_r <= ST_DRAIN;
            else begin
              ch_r    <= ch_r + 1'b1;
              state_r <= ST_CH;
            end
          end else bin_r <= bin_r + 1'b1;
        end
        ST_DRAIN: begin
          if (!(&events_r)) events_r <= events_r + 1'b1;
          for (int i = 0; i < 4; i++) begin
            jet_r[i] <= '0;
            sum_r[i] <= '0;
          end
          eg1_r <= '0;
          eg2_r <= '0;
          tau_r <= '0;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // A result only follows a read beat.
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_RD_OUT)
    else $error("result without read");
  // No input is taken while clearing.
  a_no_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> in_stall)
    else $error("accept during clear");
  // Walk bins never pass the threshold top.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> bin_r <= top_r)
    else $error("walk past top");

endmodule

// ===== verif/trigger_threshold_rate_histogrammer_top_tb.sv =====
module trigger_threshold_rate_histogrammer_top_tb;
  import tth_pkg::*;

  localparam int unsigned HBINS      = 512;
  localparam int unsigned DRAIN_WAIT = 6000;     // longest event close plus margin
  localparam int unsigned CYC_LIMIT  = 4000000;

  typedef struct {
    kind_t      kind;
    logic [3:0] slot;
    logic [10:0] et;
    logic       end_ev;
    logic [3:0] ch;
    logic       tbl;
    logic [8:0] bin;
  } trig_obj_t;

  typedef struct {
    logic [31:0] count;
    logic [31:0] events;
  } count_read_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_kind;
  logic [3:0]  in_slot;
  logic [10:0] in_et_value;
  logic        in_end_event;
  logic [3:0]  in_read_channel;
  logic        in_read_table;
  logic [8:0]  in_read_bin;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_bin_count;
  logic [31:0] out_events_seen;
  logic        cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  trigger_threshold_rate_histogrammer_top u_top (.*);

  // Predicted histogram state, mirrors the block
  logic [31:0] rate_hist [NCHAN*HBINS];
  logic [31:0] dist_hist [NCHAN*HBINS];
  logic [31:0] event_cnt;
  logic [10:0] jet_et [4];
  logic [10:0] sum_et [4];
  logic [10:0] eg_lead, eg_sub, tau_max;
  logic [8:0]  nb_jet, nb_narrow, nb_wide;
  logic [2:0]  bin_shift;

  trig_obj_t   pend_q[$];     // beats waiting for the driver
  count_read_t reads_q[$];    // read results still owed by the block
  int unsigned n_err;
  int unsigned cyc;
  int unsigned in_gap;
  int unsigned out_hold;
  bit          in_taken;
  bit          burst;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    n_err++;
  endtask

  function automatic void sat_bump(ref logic [31:0] c);
    if (c != 32'hFFFF_FFFF) c = c + 1;
  endfunction

  function automatic void hist_fill(input int unsigned ch, input logic [10:0] v,
                                    input logic [8:0] nreg);
    int unsigned n, sh, b, top;
    n = (nreg == 0) ? 1 : ((nreg > HBINS-1) ? HBINS-1 : nreg);
    sh = (bin_shift > 6) ? 6 : bin_shift;
    b = v >> sh;
    top = (b < n) ? b : n - 1;
    sat_bump(dist_hist[ch*HBINS + ((b < n) ? b : n)]);
    for (int unsigned i = 0; i <= top; i++) sat_bump(rate_hist[ch*HBINS + i]);
  endfunction

  function automatic void close_event();
    for (int i = 0; i < 4; i++) hist_fill(i, jet_et[i], nb_jet);
    hist_fill(4, eg_lead, nb_narrow);
    hist_fill(5, eg_sub, nb_narrow);
    hist_fill(6, tau_max, nb_narrow);
    hist_fill(7, sum_et[1], nb_wide);
    hist_fill(8, sum_et[3], nb_narrow);
    hist_fill(9, sum_et[0], nb_wide);
    hist_fill(10, sum_et[2], nb_narrow);
    sat_bump(event_cnt);
    for (int i = 0; i < 4; i++) begin
      jet_et[i] = '0;
      sum_et[i] = '0;
    end
    eg_lead = '0;
    eg_sub  = '0;
    tau_max = '0;
  endfunction

  // Advance the predicted state by one accepted beat
  function automatic void predict_beat(input trig_obj_t t);
    count_read_t r;
    case (t.kind)
      KIND_JET: if (t.slot < 4) jet_et[t.slot[1:0]] = t.et;
      KIND_EG: begin
        if (t.et >= eg_lead) begin
          eg_sub  = eg_lead;
          eg_lead = t.et;
        end else if (t.et > eg_sub) begin
          eg_sub = t.et;
        end
      end
      KIND_TAU: if (t.et > tau_max) tau_max = t.et;
      KIND_SUM: if (t.slot < 4) sum_et[t.slot[1:0]] = t.et;
      KIND_CLOSE: close_event();
      KIND_READ: begin
        r.count  = (t.ch < NCHAN) ?
                   (t.tbl ? dist_hist[t.ch*HBINS + t.bin] : rate_hist[t.ch*HBINS + t.bin]) : '0;
        r.events = event_cnt;
        reads_q.push_back(r);
      end
      default: ;
    endcase
    if (t.end_ev && t.kind inside {KIND_JET, KIND_EG, KIND_TAU, KIND_SUM}) close_event();
  endfunction

  // Monitor: both handshakes sampled at the rising edge
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("FAIL trigger_threshold_rate_histogrammer_top");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_beat('{kind_t'(in_kind), in_slot, in_et_value, in_end_event,
                       in_read_channel, in_read_table, in_read_bin});
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        out_hold = $urandom_range(0, 19);
        if (burst) out_hold = 0;
        if (reads_q.size() == 0) begin
          report("unexpected beat", out_bin_count, 0);
        end else begin
          if (out_bin_count !== reads_q[0].count)
            report("bin_count", out_bin_count, reads_q[0].count);
          if (out_events_seen !== reads_q[0].events)
            report("events_seen", out_events_seen, reads_q[0].events);
          void'(reads_q.pop_front());
        end
      end
    end
  end

  // Driver: inputs change at the falling edge
  always @(negedge clk) begin
    trig_obj_t t;
    if (in_valid && !in_taken) begin
      // payload holds while stalled
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_valid <= 1'b0;
    end else if (pend_q.size() != 0) begin
      t = pend_q.pop_front();
      in_kind <= t.kind;
      in_slot <= t.slot;
      in_et_value <= t.et;
      in_end_event <= t.end_ev;
      in_read_channel <= t.ch;
      in_read_table <= t.tbl;
      in_read_bin <= t.bin;
      in_valid <= 1'b1;
      in_gap <= burst ? 0 : $urandom_range(0, 19);
    end else begin
      in_valid <= 1'b0;
    end
    in_taken = 1'b0;
    if (out_hold > 0) begin
      out_hold = out_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
    if ($urandom_range(0, 199) == 0) burst = !burst;
  end

  task automatic add(input kind_t k, input int s, input int e, input bit ev,
                     input int c, input bit tb, input int b);
    pend_q.push_back('{k, s[3:0], e[10:0], ev, c[3:0], tb, b[8:0]});
  endtask

  function automatic int draw_et();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 2047;
      2: return $urandom_range(0, 2047);
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  // One event: a few objects with random content, the last one closing it
  task automatic add_event();
    int n;
    kind_t k;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      k = kind_t'($urandom_range(0, 3));
      add(k, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3),
          draw_et(), i == n-1, $urandom_range(0, 15), 1'($urandom), $urandom_range(0, 511));
    end
  endtask

  task automatic add_read();
    int b;
    b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 40);
    add(KIND_READ, $urandom_range(0, 15), $urandom_range(0, 2047), 1'($urandom),
        ($urandom_range(0, 7) == 0) ? $urandom_range(11, 15) : $urandom_range(0, 10),
        1'($urandom), b);
  endtask

  // Wait for the driver and the result queue to empty, then for a close to finish
  task automatic drain();
    while (pend_q.size() != 0 || in_valid || reads_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input int val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_JET_BINS:    nb_jet    = val[8:0];
      CFG_NARROW_BINS: nb_narrow = val[8:0];
      CFG_WIDE_BINS:   nb_wide   = val[8:0];
      default:         bin_shift = val[2:0];
    endcase
  endtask

  task automatic random_phase(input int n_beats);
    int r;
    for (int i = 0; i < n_beats; ) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        add_event();
      end else if (r < 8) begin
        add_read();
      end else if (r == 8) begin
        add(KIND_CLOSE, $urandom_range(0, 15), draw_et(), 1'($urandom), $urandom_range(0, 15),
            1'($urandom), $urandom_range(0, 511));
      end else begin
        // noise: reserved kinds or out-of-range rank/index without a close
        add(kind_t'($urandom_range(0, 1) ? $urandom_range(6, 7) : $urandom_range(0, 3)),
            $urandom_range(4, 15), draw_et(), 1'b0, $urandom_range(0, 15), 1'($urandom),
            $urandom_range(0, 511));
      end
      // at most one read after each chunk so results keep coming
      if ($urandom_range(0, 1)) add_read();
      i = i + 4;
    end
  endtask

  initial begin
    n_err = 0;
    cyc = 0;
    in_gap = 0;
    out_hold = 0;
    in_taken = 1'b0;
    burst = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = '0;
    in_slot = '0;
    in_et_value = '0;
    in_end_event = 1'b0;
    in_read_channel = '0;
    in_read_table = 1'b0;
    in_read_bin = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < NCHAN*HBINS; i++) begin
      rate_hist[i] = '0;
      dist_hist[i] = '0;
    end
    event_cnt = '0;
    for (int i = 0; i < 4; i++) begin
      jet_et[i] = '0;
      sum_et[i] = '0;
    end
    eg_lead = '0;
    eg_sub = '0;
    tau_max = '0;
    nb_jet = 9'd200;
    nb_narrow = 9'd150;
    nb_wide = 9'd300;
    bin_shift = 3'd2;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every kind, the odd cases
    add(KIND_READ, 0, 0, 0, 0, 0, 0);                    // empty memories
    add(KIND_JET, 0, 0, 0, 0, 0, 0);
    add(KIND_JET, 3, 2047, 0, 0, 0, 0);
    add(KIND_EG, 0, 100, 0, 0, 0, 0);
    add(KIND_EG, 0, 100, 0, 0, 0, 0);                    // equal to leader: old one drops
    add(KIND_EG, 0, 50, 0, 0, 0, 0);
    add(KIND_TAU, 0, 2047, 0, 0, 0, 0);
    add(KIND_TAU, 0, 7, 0, 0, 0, 0);
    for (int s = 0; s < 4; s++) add(KIND_SUM, s, 400 + 300*s, 0, 0, 0, 0);
    add(KIND_SUM, 15, 1234, 0, 0, 0, 0);                 // sum index out of range
    add(KIND_JET, 9, 500, 1, 0, 0, 0);                   // ignored rank still closes
    add(KIND_CLOSE, 0, 0, 0, 0, 0, 0);                   // empty event
    add(KIND_RSV6, 15, 2047, 1, 15, 1, 511);
    add(KIND_RSV7, 0, 0, 1, 0, 0, 0);
    add(KIND_READ, 15, 2047, 1, 15, 1, 511);             // channel out of range
    add(KIND_READ, 10, 0, 0, 10, 1, 511);
    add(KIND_READ, 3, 0, 0, 3, 0, 0);
    add(KIND_READ, 3, 0, 0, 3, 1, 200);                  // jet overflow bin
    add(KIND_READ, 6, 0, 0, 6, 0, 149);
    add(KIND_READ, 5, 0, 0, 5, 1, 12);
    random_phase(250);
    drain();

    // Smallest bins, finest shift; zero bin count acts as one bin
    cfg_write(CFG_JET_BINS, 0);
    cfg_write(CFG_NARROW_BINS, 1);
    cfg_write(CFG_WIDE_BINS, 1);
    cfg_write(CFG_SHIFT, 0);
    random_phase(150);
    drain();

    // Largest bins, shift register above the clamp
    cfg_write(CFG_JET_BINS, 511);
    cfg_write(CFG_NARROW_BINS, 511);
    cfg_write(CFG_WIDE_BINS, 511);
    cfg_write(CFG_SHIFT, 7);
    random_phase(150);
    drain();

    cfg_write(CFG_JET_BINS, 16);
    cfg_write(CFG_NARROW_BINS, 40);
    cfg_write(CFG_WIDE_BINS, 90);
    cfg_write(CFG_SHIFT, 3);
    random_phase(200);
    drain();

    // Bins of 16, 40 and 90 at full resolution, in a short run
    cfg_write(CFG_SHIFT, 0);
    random_phase(40);
    drain();

    if (n_err == 0) begin
      $display("PASS trigger_threshold_rate_histogrammer_top");
    end else begin
      $display("FAIL trigger_threshold_rate_histogrammer_top");
    end
    $finish;
  end

endmodule
